// File: rtl/fqq_pkg.sv
// Package for the queue with queries: sizes, action codes, controller states
// and the result record shared between the controller and the top level.
// Depends on nothing.
package fqq_pkg;

	localparam int DEPTH  = 16;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int ACT_W  = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_COUNT   = 2'd2,
		ACT_REVERSE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_RD,
		ST_SCAN,
		ST_SCAN_END,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  size;
		logic [CNT_W-1:0]  even_count;
		logic              error;
	} res_t;

	function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] a, logic [CNT_W-1:0] b);
		logic [PTR_W:0] sum;
		sum = (PTR_W + 1)'(a) + (PTR_W + 1)'(b);
		if (sum >= (PTR_W + 1)'(DEPTH)) begin
			sum = sum - (PTR_W + 1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

// File: rtl/fqq_if.sv
// Handshake channels of the queue: the request channel and the result channel.
// Depends on fqq_pkg for the field widths.
interface fqq_req_if import fqq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [DATA_W-1:0] value;

	modport source (output valid, action, value, input ready);
	modport sink (input valid, action, value, output ready);
endinterface

interface fqq_rsp_if import fqq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data;
	logic [CNT_W-1:0]  size;
	logic [CNT_W-1:0]  even_count;
	logic              error;

	modport source (output valid, data, size, even_count, error, input ready);
	modport sink (input valid, data, size, even_count, error, output ready);
endinterface

// File: rtl/fqq_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. Depends on nothing.
module fqq_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH_P)-1:0] waddr,
	input  logic [WIDTH_P-1:0]         wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH_P)-1:0] raddr,
	output logic [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/fqq_ctrl.sv
// Controller of the queue: takes one request at a time, keeps pointer, size,
// even count and direction, and drives the entry RAM. Depends on fqq_pkg, fqq_if.
module fqq_ctrl import fqq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fqq_req_if.sink           req,
	output logic              res_valid,
	output res_t              res,
	input  logic              res_take,
	output logic              ram_we,
	output logic [PTR_W-1:0]  ram_waddr,
	output logic [DATA_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [PTR_W-1:0]  ram_raddr,
	input  logic [DATA_W-1:0] ram_rdata
);

	state_t            state_q, state_d;
	action_t           act_q;
	logic [DATA_W-1:0] val_q;
	logic [PTR_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  evens_q;
	logic              rev_q;
	logic [PTR_W-1:0]  k_q;
	logic              pend_q;
	logic [CNT_W-1:0]  acc_q;
	logic [DATA_W-1:0] rdata_q;
	logic              err_q;
	logic              full;
	logic              empty;
	logic              last_k;
	logic              hit;
	logic [PTR_W-1:0]  front_dec;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign last_k    = (CNT_W'(k_q) + CNT_W'(1) == count_q);
	assign hit       = pend_q && ($signed(ram_rdata) > $signed(val_q));
	assign front_dec = wrap_add(front_q, CNT_W'(DEPTH - 1));

	assign req.ready          = (state_q == ST_IDLE);
	assign res_valid          = (state_q == ST_DONE);
	assign res.data           = rdata_q;
	assign res.size           = count_q;
	assign res.even_count     = evens_q;
	assign res.error          = err_q;
	assign ram_wdata          = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = wrap_add(front_q, count_q);
		ram_re    = 1'b0;
		ram_raddr = wrap_add(front_q, CNT_W'(k_q));
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (act_q)
					ACT_PUSH: begin
						state_d = ST_DONE;
						if (!full) begin
							ram_we = 1'b1;
							if (rev_q) begin
								ram_waddr = front_dec;
							end
						end
					end
					ACT_POP: begin
						if (empty) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_POP_RD;
							ram_re  = 1'b1;
							if (rev_q) begin
								ram_raddr = wrap_add(front_q, count_q - CNT_W'(1));
							end else begin
								ram_raddr = front_q;
							end
						end
					end
					ACT_COUNT: begin
						state_d = empty ? ST_DONE : ST_SCAN;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_POP_RD: begin
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				ram_re = 1'b1;
				if (last_k) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			evens_q <= '0;
			rev_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= 1'b0;
			case (state_q)
				ST_EXEC: begin
					case (act_q)
						ACT_PUSH: begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
								if (!val_q[0]) begin
									evens_q <= evens_q + CNT_W'(1);
								end
								if (rev_q) begin
									front_q <= front_dec;
								end
							end
						end
						ACT_POP: begin
							if (!empty) begin
								count_q <= count_q - CNT_W'(1);
								if (!rev_q) begin
									front_q <= wrap_add(front_q, CNT_W'(1));
								end
							end
						end
						ACT_REVERSE: begin
							rev_q <= ~rev_q;
						end
						default: begin
						end
					endcase
				end
				ST_POP_RD: begin
					if (!ram_rdata[0] && evens_q != '0) begin
						evens_q <= evens_q - CNT_W'(1);
					end
				end
				ST_SCAN: begin
					pend_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q <= action_t'(req.action);
				val_q <= req.value;
			end
			ST_EXEC: begin
				k_q     <= '0;
				acc_q   <= '0;
				rdata_q <= '0;
				err_q   <= 1'b0;
				if ((act_q == ACT_PUSH && full) || (act_q == ACT_POP && empty)) begin
					err_q <= 1'b1;
				end
			end
			ST_POP_RD: begin
				rdata_q <= ram_rdata;
			end
			ST_SCAN: begin
				k_q <= k_q + PTR_W'(1);
				if (hit) begin
					acc_q <= acc_q + CNT_W'(1);
				end
			end
			ST_SCAN_END: begin
				rdata_q <= DATA_W'(acc_q + CNT_W'(hit));
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/fifo_queue_with_queries_core.sv
// Top level of the queue with queries: controller, entry RAM and result register.
// Depends on fqq_pkg, fqq_if, fqq_ram and fqq_ctrl.
//
//   channel  direction  fields
//   req      in         action, value
//   rsp      out        data, size, even_count, error
//
// One request is taken at a time; each goes from idle to the execute state and then
// to done, a pop of a non-empty queue by way of a RAM read state, and a count over a
// non-empty queue by way of a scan that reads the held entries one after another
// through the single read port of the entry RAM and a scan end state. Reset clears
// pointer, size, even count and direction; entries need no clearing. A stalled result
// waits in the output register while the next request is taken and worked on.
module fifo_queue_with_queries_core import fqq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	fqq_req_if.sink req,
	fqq_rsp_if.source rsp
);

	logic              res_valid;
	res_t              res;
	logic              res_take;
	logic              ram_we;
	logic [PTR_W-1:0]  ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [PTR_W-1:0]  ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic              valid_q;
	res_t              out_q;

	assign res_take = !valid_q || rsp.ready;

	fqq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	fqq_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_take) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.data       = out_q.data;
	assign rsp.size       = out_q.size;
	assign rsp.even_count = out_q.even_count;
	assign rsp.error      = out_q.error;

endmodule
